/* rtl/eqor_pkg.sv */
// eqor_pkg: shared types, codes and defaults for the event queue with rescan marker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package eqor_pkg;

    // Build-time defaults
    localparam int EQOR_QUEUE_DEPTH = 16;
    localparam int EQOR_TAG_WIDTH   = 16;

    // Fixed field widths
    localparam int TAG_FIELD_W = 16;
    localparam int CNT32_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_KIND   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESCAN_KIND = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_ENT = 2'd3;

    // Configuration reset values
    localparam logic [4:0] CFG_CAPACITY_RST    = 5'd16;
    localparam logic [3:0] CFG_HIGH_KIND_RST   = 4'd5;
    localparam logic [3:0] CFG_RESCAN_KIND_RST = 4'd6;
    localparam logic [2:0] CFG_UNKNOWN_ENT_RST = 3'd0;

    typedef enum logic [2:0] {
        ACT_PUBLISH      = 3'd0,
        ACT_REPORT_LOSS  = 3'd1,
        ACT_TAKE_NEXT    = 3'd2,
        ACT_ACK_RESCAN   = 3'd3,
        ACT_CLOSE        = 3'd4,
        ACT_BACKEND_DONE = 3'd5,
        ACT_READ_STATS   = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_BUFFERS = 3'd1,
        ST_SHUT_DOWN  = 3'd2,
        ST_ALREADY    = 3'd3,
        ST_NOTHING    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        LC_OPEN    = 2'd0,
        LC_CLOSING = 2'd1,
        LC_CLOSED  = 2'd2
    } t_lifecycle;

    typedef struct packed {
        logic [2:0]             action;
        logic [3:0]             event_kind;
        logic [2:0]             ent_code;
        logic [TAG_FIELD_W-1:0] path_tag;
        logic [TAG_FIELD_W-1:0] old_path_tag;
    } t_in_item;

    typedef struct packed {
        logic [2:0]             status;
        logic                   has_event;
        logic [3:0]             out_kind;
        logic [2:0]             out_ent_code;
        logic [TAG_FIELD_W-1:0] out_path_tag;
        logic [TAG_FIELD_W-1:0] out_old_path_tag;
        logic [4:0]             queued;
        logic [CNT32_W-1:0]     delivered_count;
        logic [CNT32_W-1:0]     suppressed_count;
        logic [CNT32_W-1:0]     rescan_count;
        logic                   awaiting_rescan_flag;
        logic [1:0]             lifecycle;
    } t_out_item;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;    // latch input beat, read head slot
        logic commit;  // apply the operation, fill output register
    } t_ctl_cmd;

    function automatic logic [CNT32_W-1:0] sat_inc(input logic [CNT32_W-1:0] v);
        sat_inc = (v == {CNT32_W{1'b1}}) ? v : v + 32'd1;
    endfunction

endpackage

/* rtl/event_queue_with_overflow_rescan_unit.sv */
// event_queue_with_overflow_rescan_unit: top level of the change-event queue.
// Depends on eqor_pkg, eqor_ctrl and eqor_dpath.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-----------------------------
//  in       | input     | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  out      | output    | o_out_valid / i_out_ready | o_out_data (t_out_item)
//  cfg      | input     | i_cfg_we, no wait         | i_cfg_idx, i_cfg_data
//
// Every input beat gives exactly one output beat. An item is handled in order:
// the accept edge issues the registered read of the head slot, then the commit
// applies the operation and loads the output register. The block takes no new
// item until the commit of the current one has been made.
// A result waiting in the output register does not block the next accept;
// the commit of that next item stalls until the output register is free.
// Reset (synchronous, active low) empties the queue, clears all counters and
// flags and restores the config defaults; the slot memory is not cleared.

module event_queue_with_overflow_rescan_unit
    import eqor_pkg::*;
#(
    parameter int QUEUE_DEPTH = EQOR_QUEUE_DEPTH,
    parameter int TAG_WIDTH   = EQOR_TAG_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // operation beats
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    // result beats
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    t_ctl_cmd w_cmd;

    // sequencer: handshakes and output-register occupancy
    eqor_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // queue storage, flags, saturating statistics, result register
    eqor_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_WIDTH   (TAG_WIDTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

/* rtl/eqor_ctrl.sv */
// eqor_ctrl: two-state sequencer for the event queue; owns the handshakes.
// Depends on eqor_pkg (t_ctl_cmd).
`timescale 1ns / 1ps

module eqor_ctrl
    import eqor_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_ctl_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_out_free;

    // output register free now or emptied this edge
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.commit = (r_state == S_EXEC) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (w_out_free) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/eqor_dpath.sv */
// eqor_dpath: slot memory, indices, flags, counters, config registers, result register.
// Depends on eqor_pkg; driven by commands from eqor_ctrl.
`timescale 1ns / 1ps

module eqor_dpath
    import eqor_pkg::*;
#(
    parameter int QUEUE_DEPTH = EQOR_QUEUE_DEPTH,
    parameter int TAG_WIDTH   = EQOR_TAG_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_ctl_cmd              i_cmd,
    input  t_in_item              i_in_data,
    output t_out_item             o_out_data
);

    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CMP_W    = ((CNT_W > 5) ? CNT_W : 5) + 1;
    localparam int TAG_KEEP = (TAG_WIDTH < TAG_FIELD_W) ? TAG_WIDTH : TAG_FIELD_W;
    localparam int SLOT_W   = 4 + 3 + 2 * TAG_KEEP;

    // config
    logic [4:0] r_cfg_cap;
    logic [3:0] r_cfg_high_kind;
    logic [3:0] r_cfg_rescan_kind;
    logic [2:0] r_cfg_unknown_ent;

    // queue state
    logic [SLOT_W-1:0] r_mem [QUEUE_DEPTH];
    logic [SLOT_W-1:0] r_rd_slot;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_held, n_held;
    logic [CNT32_W-1:0] r_deliv, n_deliv;
    logic [CNT32_W-1:0] r_supp, n_supp;
    logic [CNT32_W-1:0] r_rescan, n_rescan;
    logic [CNT32_W-1:0] r_snap, n_snap;
    logic r_await, n_await;
    logic r_pend, n_pend;
    logic r_taken, n_taken;
    logic r_close, n_close;
    logic r_bdone, n_bdone;

    t_in_item  r_in;
    t_out_item r_out, n_out;

    logic [CMP_W-1:0]  w_cap_raw;
    logic [CMP_W-1:0]  w_cap;
    logic [CMP_W-1:0]  w_head_inc;
    logic [CMP_W-1:0]  w_tail_inc;
    logic [CMP_W-1:0]  w_queued;
    logic              w_full;
    logic              w_mem_we;
    logic [SLOT_W-1:0] w_wr_slot;

    // effective capacity: 0 acts as 1, clamp to built depth
    assign w_cap_raw = {{(CMP_W-5){1'b0}}, r_cfg_cap};
    always_comb begin
        priority if (w_cap_raw == '0) begin
            w_cap = CMP_W'(1);
        end else if (w_cap_raw > CMP_W'(QUEUE_DEPTH)) begin
            w_cap = CMP_W'(QUEUE_DEPTH);
        end else begin
            w_cap = w_cap_raw;
        end
    end

    assign w_full     = {{(CMP_W-CNT_W){1'b0}}, r_held} >= w_cap;
    assign w_head_inc = {{(CMP_W-IDX_W){1'b0}}, r_head} + CMP_W'(1);
    assign w_tail_inc = {{(CMP_W-IDX_W){1'b0}}, r_tail} + CMP_W'(1);
    assign w_wr_slot  = {r_in.event_kind, r_in.ent_code,
                         r_in.path_tag[TAG_KEEP-1:0], r_in.old_path_tag[TAG_KEEP-1:0]};

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_held   = r_held;
        n_deliv  = r_deliv;
        n_supp   = r_supp;
        n_rescan = r_rescan;
        n_snap   = r_snap;
        n_await  = r_await;
        n_pend   = r_pend;
        n_taken  = r_taken;
        n_close  = r_close;
        n_bdone  = r_bdone;
        w_mem_we = 1'b0;
        n_out    = '0;
        n_out.status = ST_OK;

        unique case (t_action'(r_in.action))
            ACT_PUBLISH: begin
                if (r_in.event_kind > r_cfg_high_kind) begin
                    n_supp = sat_inc(r_supp);
                    if (!r_await) begin
                        n_await  = 1'b1;
                        n_pend   = 1'b1;
                        n_taken  = 1'b0;
                        n_rescan = sat_inc(r_rescan);
                    end
                    n_out.status = ST_NO_BUFFERS;
                end else if (r_close) begin
                    n_supp       = sat_inc(r_supp);
                    n_out.status = ST_SHUT_DOWN;
                end else if (r_await || w_full) begin
                    n_supp = sat_inc(r_supp);
                    if (!r_await) begin
                        n_await  = 1'b1;
                        n_pend   = 1'b1;
                        n_taken  = 1'b0;
                        n_rescan = sat_inc(r_rescan);
                    end
                    n_out.status = ST_NO_BUFFERS;
                end else begin
                    w_mem_we = 1'b1;
                    n_tail   = (w_tail_inc >= w_cap) ? '0 : w_tail_inc[IDX_W-1:0];
                    n_held   = r_held + CNT_W'(1);
                end
            end
            ACT_REPORT_LOSS: begin
                n_supp = sat_inc(r_supp);
                if (!r_await) begin
                    n_await  = 1'b1;
                    n_pend   = 1'b1;
                    n_taken  = 1'b0;
                    n_rescan = sat_inc(r_rescan);
                end
            end
            ACT_TAKE_NEXT: begin
                if (r_held != '0) begin
                    n_out.has_event        = 1'b1;
                    n_out.out_kind         = r_rd_slot[SLOT_W-1 -: 4];
                    n_out.out_ent_code     = r_rd_slot[SLOT_W-5 -: 3];
                    n_out.out_path_tag     = TAG_FIELD_W'(r_rd_slot[2*TAG_KEEP-1 -: TAG_KEEP]);
                    n_out.out_old_path_tag = TAG_FIELD_W'(r_rd_slot[TAG_KEEP-1:0]);
                    n_head  = (w_head_inc >= w_cap) ? '0 : w_head_inc[IDX_W-1:0];
                    n_held  = r_held - CNT_W'(1);
                    n_deliv = sat_inc(r_deliv);
                end else if (r_pend) begin
                    n_pend  = 1'b0;
                    n_taken = 1'b1;
                    n_snap  = r_supp;
                    n_out.has_event    = 1'b1;
                    n_out.out_kind     = r_cfg_rescan_kind;
                    n_out.out_ent_code = r_cfg_unknown_ent;
                    n_deliv = sat_inc(r_deliv);
                end else begin
                    n_out.status = ST_NOTHING;
                end
            end
            ACT_ACK_RESCAN: begin
                if (!r_await || !r_taken) begin
                    n_out.status = ST_ALREADY;
                end else if (r_supp != r_snap) begin
                    // drops since the marker went out: re-arm
                    n_pend   = 1'b1;
                    n_taken  = 1'b0;
                    n_rescan = sat_inc(r_rescan);
                end else begin
                    n_await = 1'b0;
                    n_taken = 1'b0;
                end
            end
            ACT_CLOSE: begin
                if (r_close) begin
                    n_out.status = ST_ALREADY;
                end else begin
                    n_close = 1'b1;
                end
            end
            ACT_BACKEND_DONE: begin
                n_bdone = 1'b1;
            end
            default: begin
            end
        endcase

        w_queued = {{(CMP_W-CNT_W){1'b0}}, n_held} + CMP_W'(n_pend);
        n_out.queued               = w_queued[4:0];
        n_out.delivered_count      = n_deliv;
        n_out.suppressed_count     = n_supp;
        n_out.rescan_count         = n_rescan;
        n_out.awaiting_rescan_flag = n_await;
        n_out.lifecycle            = !n_close ? LC_OPEN : (n_bdone ? LC_CLOSED : LC_CLOSING);
    end

    // slot memory: write at tail on commit, registered read of head on load
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_mem_we) begin
            r_mem[r_tail] <= w_wr_slot;
        end
        if (i_cmd.load) begin
            r_rd_slot <= r_mem[r_head];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    // control state and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head            <= '0;
            r_tail            <= '0;
            r_held            <= '0;
            r_deliv           <= '0;
            r_supp            <= '0;
            r_rescan          <= '0;
            r_snap            <= '0;
            r_await           <= 1'b0;
            r_pend            <= 1'b0;
            r_taken           <= 1'b0;
            r_close           <= 1'b0;
            r_bdone           <= 1'b0;
            r_cfg_cap         <= CFG_CAPACITY_RST;
            r_cfg_high_kind   <= CFG_HIGH_KIND_RST;
            r_cfg_rescan_kind <= CFG_RESCAN_KIND_RST;
            r_cfg_unknown_ent <= CFG_UNKNOWN_ENT_RST;
        end else begin
            if (i_cmd.commit) begin
                r_head   <= n_head;
                r_tail   <= n_tail;
                r_held   <= n_held;
                r_deliv  <= n_deliv;
                r_supp   <= n_supp;
                r_rescan <= n_rescan;
                r_snap   <= n_snap;
                r_await  <= n_await;
                r_pend   <= n_pend;
                r_taken  <= n_taken;
                r_close  <= n_close;
                r_bdone  <= n_bdone;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CAPACITY:    r_cfg_cap         <= i_cfg_data;
                    CFG_HIGH_KIND:   r_cfg_high_kind   <= i_cfg_data[3:0];
                    CFG_RESCAN_KIND: r_cfg_rescan_kind <= i_cfg_data[3:0];
                    CFG_UNKNOWN_ENT: r_cfg_unknown_ent <= i_cfg_data[2:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out_data = r_out;

endmodule
